// File: src/pol_pkg.sv
// ----------------------------------------------------------------------------
// pol_pkg
// Shared types and codes for the positional ordered list.
// ----------------------------------------------------------------------------
package pol_pkg;

    localparam int unsigned LEN_W = 7;
    localparam int unsigned VAL_W = 32;

    localparam logic [2:0] OP_INS_FRONT = 3'd0;
    localparam logic [2:0] OP_INS_BACK  = 3'd1;
    localparam logic [2:0] OP_INS_AT    = 3'd2;
    localparam logic [2:0] OP_DEL_FRONT = 3'd3;
    localparam logic [2:0] OP_DEL_BACK  = 3'd4;
    localparam logic [2:0] OP_DEL_AT    = 3'd5;
    localparam logic [2:0] OP_LIST      = 3'd6;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [2:0]              operation;
        logic signed [VAL_W-1:0] value;
        logic [LEN_W-1:0]        position;
    } req_t;

    typedef struct packed {
        logic [1:0]              status;
        logic signed [VAL_W-1:0] item_value;
        logic                    last;
    } rsp_t;

    typedef enum logic [0:0] {
        S_IDLE,
        S_LIST
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic exec;
        logic list_step;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic len_zero;
        logic list_last;
    } sts_t;

endpackage

// File: src/pol_ctrl.sv
// ----------------------------------------------------------------------------
// pol_ctrl
// Controller: takes requests while idle and sequences a listing.
// ----------------------------------------------------------------------------
module pol_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic [2:0]       operation,
    input  pol_pkg::sts_t    sts,
    output pol_pkg::cmd_t    cmd
);
    import pol_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (cmd.exec && operation == OP_LIST && !sts.len_zero)
                begin
                    state_next = S_LIST;
                end
            end
            S_LIST:
            begin
                if (cmd.list_step && sts.list_last)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        req_ready     = 1'b0;
        cmd.exec      = 1'b0;
        cmd.list_step = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                req_ready = sts.out_free;
                cmd.exec  = req_valid && sts.out_free;
            end
            S_LIST:
            begin
                cmd.list_step = sts.out_free;
            end
            default:
            begin
                req_ready = 1'b0;
            end
        endcase
    end

endmodule

// File: src/pol_dp.sv
// ----------------------------------------------------------------------------
// pol_dp
// Datapath: row of shifting entry cells, length, list counter, output register.
// ----------------------------------------------------------------------------
module pol_dp
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  pol_pkg::req_t req,
    input  pol_pkg::cmd_t cmd,
    output pol_pkg::sts_t sts,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output pol_pkg::rsp_t rsp
);
    import pol_pkg::*;

    localparam logic [LEN_W-1:0] DEPTH_L = LEN_W'(DEPTH);

    logic [VAL_W-1:0] entries_reg [DEPTH];
    logic [VAL_W-1:0] entries_next [DEPTH];
    logic [VAL_W-1:0] prev_w [DEPTH];
    logic [VAL_W-1:0] succ_w [DEPTH];

    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;
    logic [LEN_W-1:0] cnt_reg;
    logic [LEN_W-1:0] cnt_next;
    logic             rsp_valid_reg;
    logic             rsp_valid_next;
    rsp_t             rsp_reg;
    rsp_t             rsp_next;

    logic             do_ins;
    logic             do_del;
    logic [LEN_W-1:0] idx;
    logic [1:0]       st;
    logic             emit;
    logic [VAL_W-1:0] del_val;
    logic [LEN_W:0]   pos_x;
    logic [LEN_W:0]   len_x;
    logic             full;
    logic             len_zero;

    // neighbour taps of each cell
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_tap
        if (g > 0)
        begin : g_prev
            assign prev_w[g] = entries_reg[g-1];
        end
        else
        begin : g_prev0
            assign prev_w[g] = '0;
        end
        if (g < DEPTH - 1)
        begin : g_succ
            assign succ_w[g] = entries_reg[g+1];
        end
        else
        begin : g_succ_end
            assign succ_w[g] = entries_reg[g];
        end
    end

    assign pos_x    = {1'b0, req.position};
    assign len_x    = {1'b0, length_reg};
    assign full     = length_reg >= DEPTH_L;
    assign len_zero = length_reg == '0;

    // decode the operation and check bounds
    always_comb
    begin
        do_ins = 1'b0;
        do_del = 1'b0;
        idx    = '0;
        st     = ST_OK;
        emit   = 1'b1;
        case (req.operation)
            OP_INS_FRONT, OP_INS_BACK, OP_INS_AT:
            begin
                if (req.operation == OP_INS_BACK)
                begin
                    idx = length_reg;
                end
                else if (req.operation == OP_INS_AT)
                begin
                    idx = req.position - LEN_W'(1);
                end
                if (req.operation == OP_INS_AT &&
                    (req.position == '0 || pos_x > len_x + (LEN_W+1)'(1)))
                begin
                    st = ST_RANGE;
                end
                else if (full)
                begin
                    st = ST_FULL;
                end
                else
                begin
                    do_ins = 1'b1;
                end
            end
            OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_AT:
            begin
                if (req.operation == OP_DEL_BACK)
                begin
                    idx = length_reg - LEN_W'(1);
                end
                else if (req.operation == OP_DEL_AT)
                begin
                    idx = req.position - LEN_W'(1);
                end
                if (len_zero)
                begin
                    st = ST_EMPTY;
                end
                else if (req.operation == OP_DEL_AT &&
                         (req.position == '0 || req.position > length_reg))
                begin
                    st = ST_RANGE;
                end
                else
                begin
                    do_del = 1'b1;
                end
            end
            OP_LIST:
            begin
                st   = ST_EMPTY;
                emit = len_zero;
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    // pick the entry being removed
    always_comb
    begin
        del_val = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (idx == LEN_W'(i))
            begin
                del_val = entries_reg[i];
            end
        end
    end

    // each cell holds, loads, or takes a neighbour
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            entries_next[i] = entries_reg[i];
            if (cmd.exec && do_ins)
            begin
                if (LEN_W'(i) == idx)
                begin
                    entries_next[i] = req.value;
                end
                else if (LEN_W'(i) > idx)
                begin
                    entries_next[i] = prev_w[i];
                end
            end
            else if (cmd.exec && do_del)
            begin
                if (LEN_W'(i) >= idx)
                begin
                    entries_next[i] = succ_w[i];
                end
            end
            else if (cmd.list_step)
            begin
                // rotate the occupied part so the front wraps to the back
                if (LEN_W'(i) == length_reg - LEN_W'(1))
                begin
                    entries_next[i] = entries_reg[0];
                end
                else if (LEN_W'(i) < length_reg)
                begin
                    entries_next[i] = succ_w[i];
                end
            end
        end
    end

    always_comb
    begin
        length_next    = length_reg;
        cnt_next       = cnt_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        if (cmd.exec)
        begin
            cnt_next = '0;
            if (do_ins)
            begin
                length_next = length_reg + LEN_W'(1);
            end
            else if (do_del)
            begin
                length_next = length_reg - LEN_W'(1);
            end
            if (emit)
            begin
                rsp_valid_next      = 1'b1;
                rsp_next.status     = st;
                rsp_next.last       = 1'b1;
                rsp_next.item_value = '0;
                if (do_ins)
                begin
                    rsp_next.item_value = req.value;
                end
                else if (do_del)
                begin
                    rsp_next.item_value = del_val;
                end
            end
        end
        else if (cmd.list_step)
        begin
            cnt_next            = cnt_reg + LEN_W'(1);
            rsp_valid_next      = 1'b1;
            rsp_next.status     = ST_OK;
            rsp_next.item_value = entries_reg[0];
            rsp_next.last       = sts.list_last;
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
        rsp_reg     <= rsp_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            length_reg    <= '0;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            length_reg    <= length_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign sts.out_free  = !rsp_valid_reg || rsp_ready;
    assign sts.len_zero  = len_zero;
    assign sts.list_last = (cnt_reg + LEN_W'(1)) == length_reg;

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// File: src/positional_ordered_list.sv
// Insert and delete: the result is registered in the cycle after the request is taken.
// Listing: one result per cycle while the output register is free, for the current length, by rotating the entry row.
// A request is taken only while no listing runs and the output register is free.
// Reset clears length and control; entry storage is not cleared.
// ----------------------------------------------------------------------------
// positional_ordered_list
// Ordered list of signed words with positional insert, delete and listing.
// ----------------------------------------------------------------------------
module positional_ordered_list
#(
    parameter int unsigned DEPTH = 64
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  pol_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output pol_pkg::rsp_t rsp
);
    import pol_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pol_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .operation (req.operation),
        .sts       (sts),
        .cmd       (cmd)
    );

    pol_dp #(.DEPTH(DEPTH)) u_dp
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

endmodule
